/* rtl/wmh_pkg.sv */
package wmh_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int ANGLE_W = 25;
    localparam int HOP_W = 10;
    localparam int QUOT_W = 9;
    localparam int NUM_W = ANGLE_W + 2;
    localparam int PROD_W = QUOT_W + ANGLE_W;
    localparam int HI_W = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(360 * (1 << ANGLE_FRAC_BITS));
    localparam logic [ANGLE_W-1:0] ONE_DEGREE = ANGLE_W'(1 << ANGLE_FRAC_BITS);

    localparam logic [ANGLE_W-1:0] PLANE_SPACING_RST = ANGLE_W'(30 * (1 << ANGLE_FRAC_BITS));
    localparam logic [ANGLE_W-1:0] SLOT_SPACING_RST = ANGLE_W'(36 * (1 << ANGLE_FRAC_BITS));
    localparam logic [ANGLE_W-1:0] PHASING_OFFSET_RST = '0;

    // whole-degree part of a product reduced mod 360 via reciprocal
    localparam logic [HI_W-1:0] DEG_TURN = HI_W'(360);
    localparam logic [HI_W-1:0] RECIP_360 = HI_W'(93207);
    localparam int RECIP_SH = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANE_SPACING = 2'd0,
        CFG_SLOT_SPACING = 2'd1,
        CFG_PHASING_OFFSET = 2'd2
    } cfg_index_t;

    function automatic logic [ANGLE_W-1:0] reduce_turn(input logic [ANGLE_W-1:0] x);
        logic [ANGLE_W-1:0] r;
        r = (x >= FULL_TURN) ? (x - FULL_TURN) : x;
        return r;
    endfunction

    // (b - a) folded into one turn
    function automatic logic [ANGLE_W-1:0] fold_diff(input logic [ANGLE_W-1:0] b,
                                                     input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W:0] d;
        d = {1'b0, b} - {1'b0, a};
        if (d[ANGLE_W])
        begin
            d = d + {1'b0, FULL_TURN};
        end
        return d[ANGLE_W-1:0];
    endfunction

endpackage

/* rtl/wmh_div.sv */
module wmh_div #(
    parameter int LANES = 2,
    parameter int SIDE_W = 1
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [LANES-1:0][wmh_pkg::ANGLE_W-1:0]     in_a,
    input  logic [SIDE_W-1:0]                          in_side,
    input  logic [wmh_pkg::ANGLE_W-1:0]                spacing,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [LANES-1:0][wmh_pkg::QUOT_W-1:0]      out_q,
    output logic [SIDE_W-1:0]                          out_side
);

    // round half up: q = (2a + s) / (2s), one quotient bit per stage
    localparam int QW = wmh_pkg::QUOT_W;
    localparam int NW = wmh_pkg::NUM_W;
    localparam int CW = NW + QW;

    logic [QW:0]     v_reg;
    logic [QW+1:0]   en;
    logic [NW-1:0]   rem_reg [QW+1][LANES];
    logic [QW-1:0]   q_reg [QW+1][LANES];
    logic [SIDE_W-1:0] side_reg [QW+1];
    logic [CW-1:0]   dbl;

    assign dbl = CW'({spacing, 1'b0});
    assign en[QW+1] = out_ready;
    assign in_ready = en[0];
    assign out_valid = v_reg[QW];
    assign out_side = side_reg[QW];

    genvar k, l;
    generate
        for (k = 0; k <= QW; k++)
        begin : g_en
            assign en[k] = !v_reg[k] || en[k+1];
        end
        for (l = 0; l < LANES; l++)
        begin : g_out
            assign out_q[l] = q_reg[QW][l];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i <= QW; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < LANES; i++)
            begin
                rem_reg[0][i] <= NW'({in_a[i], 1'b0}) + NW'(spacing);
                q_reg[0][i] <= '0;
            end
            side_reg[0] <= in_side;
        end
    end

    generate
        for (k = 1; k <= QW; k++)
        begin : g_step
            localparam int B = QW - k;
            logic [CW-1:0] dsh;
            logic [NW-1:0] rem_next [LANES];
            logic [QW-1:0] q_next [LANES];

            assign dsh = dbl << B;

            always_comb
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    q_next[i] = q_reg[k-1][i];
                    if (CW'(rem_reg[k-1][i]) >= dsh)
                    begin
                        rem_next[i] = NW'(CW'(rem_reg[k-1][i]) - dsh);
                        q_next[i][B] = 1'b1;
                    end
                    else
                    begin
                        rem_next[i] = rem_reg[k-1][i];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        rem_reg[k][i] <= rem_next[i];
                        q_reg[k][i] <= q_next[i];
                    end
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    endgenerate

endmodule

/* rtl/wmh_shift.sv */
module wmh_shift (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [wmh_pkg::QUOT_W-1:0]      in_west,
    input  logic [wmh_pkg::QUOT_W-1:0]      in_east,
    input  logic [wmh_pkg::ANGLE_W-1:0]     in_phase,
    input  logic [wmh_pkg::ANGLE_W-1:0]     offset,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [wmh_pkg::ANGLE_W-1:0]     u_west,
    output logic [wmh_pkg::ANGLE_W-1:0]     u_east,
    output logic [wmh_pkg::QUOT_W-1:0]      out_west,
    output logic [wmh_pkg::QUOT_W-1:0]      out_east
);

    localparam int AW = wmh_pkg::ANGLE_W;
    localparam int QW = wmh_pkg::QUOT_W;
    localparam int PW = wmh_pkg::PROD_W;
    localparam int HW = wmh_pkg::HI_W;
    localparam int FB = wmh_pkg::ANGLE_FRAC_BITS;

    logic [3:0] v_reg;
    logic [4:0] en;

    logic [QW-1:0] w_reg [4];
    logic [QW-1:0] e_reg [4];
    logic [AW-1:0] ph_reg [3];

    logic [PW-1:0]   pw_reg, pe_reg;
    logic [HW-1:0]   hw_reg, he_reg;
    logic [FB-1:0]   lw_reg, le_reg;
    logic [2*HW-1:0] tw_reg, te_reg;
    logic [AW-1:0]   sw_reg, se_reg;
    logic [AW-1:0]   uw_reg, ue_reg;

    logic [HW-1:0] rw, re;
    logic [AW:0]   sum_w, dif_e;

    assign en[4] = out_ready;
    assign en[3] = !v_reg[3] || en[4];
    assign en[2] = !v_reg[2] || en[3];
    assign en[1] = !v_reg[1] || en[2];
    assign en[0] = !v_reg[0] || en[1];
    assign in_ready = en[0];
    assign out_valid = v_reg[3];
    assign u_west = uw_reg;
    assign u_east = ue_reg;
    assign out_west = w_reg[3];
    assign out_east = e_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
            if (en[3]) v_reg[3] <= v_reg[2];
        end
    end

    // residue of whole degrees mod 360, quotient from reciprocal is exact here
    always_comb
    begin
        rw = hw_reg - HW'(tw_reg[wmh_pkg::RECIP_SH +: QW]) * wmh_pkg::DEG_TURN;
        re = he_reg - HW'(te_reg[wmh_pkg::RECIP_SH +: QW]) * wmh_pkg::DEG_TURN;
        sum_w = {1'b0, ph_reg[2]} + {1'b0, sw_reg};
        if (sum_w >= {1'b0, wmh_pkg::FULL_TURN})
        begin
            sum_w = sum_w - {1'b0, wmh_pkg::FULL_TURN};
        end
        dif_e = {1'b0, ph_reg[2]} - {1'b0, se_reg};
        if (dif_e[AW])
        begin
            dif_e = dif_e + {1'b0, wmh_pkg::FULL_TURN};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pw_reg <= PW'(in_west) * PW'(offset);
            pe_reg <= PW'(in_east) * PW'(offset);
            w_reg[0] <= in_west;
            e_reg[0] <= in_east;
            ph_reg[0] <= in_phase;
        end
        if (en[1])
        begin
            hw_reg <= pw_reg[FB +: HW];
            he_reg <= pe_reg[FB +: HW];
            lw_reg <= pw_reg[FB-1:0];
            le_reg <= pe_reg[FB-1:0];
            tw_reg <= (2*HW)'(pw_reg[FB +: HW]) * (2*HW)'(wmh_pkg::RECIP_360);
            te_reg <= (2*HW)'(pe_reg[FB +: HW]) * (2*HW)'(wmh_pkg::RECIP_360);
            w_reg[1] <= w_reg[0];
            e_reg[1] <= e_reg[0];
            ph_reg[1] <= ph_reg[0];
        end
        if (en[2])
        begin
            sw_reg <= {rw[QW-1:0], lw_reg};
            se_reg <= {re[QW-1:0], le_reg};
            w_reg[2] <= w_reg[1];
            e_reg[2] <= e_reg[1];
            ph_reg[2] <= ph_reg[1];
        end
        if (en[3])
        begin
            uw_reg <= sum_w[AW-1:0];
            ue_reg <= dif_e[AW-1:0];
            w_reg[3] <= w_reg[2];
            e_reg[3] <= e_reg[2];
        end
    end

endmodule

/* rtl/walker_min_hop_count_unit.sv */
// Minimum hop counts through a Walker-delta grid.
// Input stream s_*: one transaction carries source and destination phase and
// node angles (degrees, 16 fractional bits). Output stream m_*: one transaction
// with the west-up, west-down, east-up and east-down hop counts per input.
// Config channel cfg_*: index 0 plane spacing, 1 slot spacing, 2 phasing
// offset; cfg_ready is always high. The user must make writes only while
// the pipeline is empty; nothing in the block enforces this. Pipeline: 2 front
// stages, 10-stage plane divider, 4-stage phasing correction, 10-stage
// in-plane divider, output register. Throughput: one transaction per cycle
// unless the receiver stalls; each divider resolves one quotient bit per stage.
// Reset clears all stage valids and loads 30/36/0 degree config values.
// A stalled receiver holds m_tdata; stages keep filling bubbles until the
// pipeline is full, then s_tready drops. Nothing is lost or repeated.
module walker_min_hop_count_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // src_phase, src_node, dst_phase, dst_node (25 bits each), 4 zero bits
    input  logic [103:0]                    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hops_west_up, hops_west_down, hops_east_up, hops_east_down (10 bits each)
    output logic [39:0]                     m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wmh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wmh_pkg::ANGLE_W-1:0]     cfg_data
);

    localparam int AW = wmh_pkg::ANGLE_W;
    localparam int QW = wmh_pkg::QUOT_W;
    localparam int HW = wmh_pkg::HOP_W;

    logic [AW-1:0] ps_reg, ss_reg, off_reg;

    logic          a_v_reg, b_v_reg, o_v_reg;
    logic          en_a, en_b, en_o;
    logic [AW-1:0] sp_reg, sn_reg, dp_reg, dn_reg;
    logic [AW-1:0] node_d_reg, phase_d_reg;
    logic [39:0]   tdata_reg;

    logic                 d1_in_ready, d1_out_valid;
    logic [1:0][AW-1:0]   d1_a;
    logic [1:0][QW-1:0]   d1_q;
    logic [AW-1:0]        d1_side;

    logic                 sh_in_ready, sh_out_valid;
    logic [AW-1:0]        u_w, u_e;
    logic [QW-1:0]        sh_west, sh_east;

    logic                 d2_in_ready, d2_out_valid;
    logic [3:0][AW-1:0]   d2_a;
    logic [3:0][QW-1:0]   d2_q;
    logic [2*QW-1:0]      d2_side;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg <= wmh_pkg::PLANE_SPACING_RST;
            ss_reg <= wmh_pkg::SLOT_SPACING_RST;
            off_reg <= wmh_pkg::PHASING_OFFSET_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                wmh_pkg::CFG_PLANE_SPACING:
                begin
                    ps_reg <= (cfg_data < wmh_pkg::ONE_DEGREE) ? wmh_pkg::ONE_DEGREE : cfg_data;
                end
                wmh_pkg::CFG_SLOT_SPACING:
                begin
                    ss_reg <= (cfg_data < wmh_pkg::ONE_DEGREE) ? wmh_pkg::ONE_DEGREE : cfg_data;
                end
                wmh_pkg::CFG_PHASING_OFFSET:
                begin
                    off_reg <= wmh_pkg::reduce_turn(cfg_data);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign en_o = !o_v_reg || m_tready;
    assign en_b = !b_v_reg || d1_in_ready;
    assign en_a = !a_v_reg || en_b;
    assign s_tready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (en_a) a_v_reg <= s_tvalid;
            if (en_b) b_v_reg <= a_v_reg;
            if (en_o) o_v_reg <= d2_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            sp_reg <= wmh_pkg::reduce_turn(s_tdata[24:0]);
            sn_reg <= wmh_pkg::reduce_turn(s_tdata[49:25]);
            dp_reg <= wmh_pkg::reduce_turn(s_tdata[74:50]);
            dn_reg <= wmh_pkg::reduce_turn(s_tdata[99:75]);
        end
        if (en_b)
        begin
            node_d_reg <= wmh_pkg::fold_diff(dn_reg, sn_reg);
            phase_d_reg <= wmh_pkg::fold_diff(dp_reg, sp_reg);
        end
        if (en_o)
        begin
            tdata_reg <= {HW'(d2_side[2*QW-1:QW]) + HW'(d2_q[3]),
                          HW'(d2_side[2*QW-1:QW]) + HW'(d2_q[2]),
                          HW'(d2_side[QW-1:0]) + HW'(d2_q[1]),
                          HW'(d2_side[QW-1:0]) + HW'(d2_q[0])};
        end
    end

    // lane 0 west, lane 1 east
    assign d1_a[0] = wmh_pkg::FULL_TURN - node_d_reg;
    assign d1_a[1] = node_d_reg;

    wmh_div #(
        .LANES(2),
        .SIDE_W(AW)
    ) u_div_plane (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(b_v_reg),
        .in_ready(d1_in_ready),
        .in_a(d1_a),
        .in_side(phase_d_reg),
        .spacing(ps_reg),
        .out_valid(d1_out_valid),
        .out_ready(sh_in_ready),
        .out_q(d1_q),
        .out_side(d1_side)
    );

    wmh_shift u_shift (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(d1_out_valid),
        .in_ready(sh_in_ready),
        .in_west(d1_q[0]),
        .in_east(d1_q[1]),
        .in_phase(d1_side),
        .offset(off_reg),
        .out_valid(sh_out_valid),
        .out_ready(d2_in_ready),
        .u_west(u_w),
        .u_east(u_e),
        .out_west(sh_west),
        .out_east(sh_east)
    );

    assign d2_a[0] = u_w;
    assign d2_a[1] = wmh_pkg::FULL_TURN - u_w;
    assign d2_a[2] = u_e;
    assign d2_a[3] = wmh_pkg::FULL_TURN - u_e;

    wmh_div #(
        .LANES(4),
        .SIDE_W(2 * QW)
    ) u_div_slot (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(sh_out_valid),
        .in_ready(d2_in_ready),
        .in_a(d2_a),
        .in_side({sh_east, sh_west}),
        .spacing(ss_reg),
        .out_valid(d2_out_valid),
        .out_ready(en_o),
        .out_q(d2_q),
        .out_side(d2_side)
    );

    assign m_tvalid = o_v_reg;
    assign m_tdata = tdata_reg;

endmodule

/* rtl/wmh_chk.sv */
module wmh_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [39:0]                     m_tdata,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    a_hop_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[9:0] <= 10'd720) && (m_tdata[19:10] <= 10'd720) &&
                     (m_tdata[29:20] <= 10'd720) && (m_tdata[39:30] <= 10'd720))
        else $error("hop count above 720");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write not taken");

endmodule

bind walker_min_hop_count_unit wmh_chk u_wmh_chk (
    .clk(clk),
    .rst_n(rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
);
